FILE: rtl/core/sxf_pkg.sv
`default_nettype none

package sxf_pkg;

  // Default screen size in pixels.
  localparam int SCREEN_WIDTH_DEF  = 64;
  localparam int SCREEN_HEIGHT_DEF = 32;

  // Pixels in one sprite row.
  localparam int SPRITE_W = 8;

  // Fixed-point shift used for the reciprocal that replaces a constant modulo.
  localparam int RECIP_SHIFT = 16;

  // Entries in the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [3:0] row_number;
    logic [7:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic collision;
    logic pixel_value;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_t  op;
    logic row_ok;     // row lies on screen, so the draw writes
    logic row_start;  // first row of a sprite, clears the collision flag
  } cmd_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/sxf_front.sv
`default_nettype none

module sxf_front
  import sxf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  localparam int XW = $clog2(SCREEN_WIDTH),
  localparam int YW = $clog2(SCREEN_HEIGHT)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    clip_mode,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire in_item_t                in_data,
  output logic                         cmd_valid,
  input  wire logic                    cmd_ready,
  output cmd_ctrl_t                    cmd_ctrl,
  output logic [YW-1:0]                cmd_row,
  output logic [XW-1:0]                cmd_col,
  output logic [SCREEN_WIDTH-1:0]      cmd_mask
);

  // Reciprocals, rounded up; exact floor quotients for operands below 512.
  localparam int MX = ((1 << RECIP_SHIFT) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
  localparam int MY = ((1 << RECIP_SHIFT) + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT;
  localparam int PW = 9 + RECIP_SHIFT + 1;
  localparam int QW = PW - RECIP_SHIFT;
  localparam int EW = SCREEN_WIDTH + SPRITE_W;

  logic          a_valid;
  in_item_t      a_item;
  logic [QW-1:0] a_qx;
  logic [QW-1:0] a_qy;
  logic [QW-1:0] a_qs;

  logic          advance;
  logic [PW-1:0] prod_x;
  logic [PW-1:0] prod_y;
  logic [PW-1:0] prod_s;
  logic [QW-1:0] y_sum_in;

  logic [QW-1:0] h_full;
  logic [QW-1:0] v_full;
  logic [QW-1:0] w_full;
  logic [QW-1:0] y_clip;
  logic [QW-1:0] y_sum_a;
  logic [SPRITE_W-1:0] rev_bits;
  logic [EW-1:0] ext;

  assign advance   = !a_valid || cmd_ready;
  assign in_ready  = advance;
  assign cmd_valid = a_valid;

  // First stage: quotients by the screen size.
  always_comb begin
    y_sum_in = QW'(in_data.y_pos) + QW'(in_data.row_number);
    prod_x   = PW'(in_data.x_pos) * PW'(MX);
    prod_y   = PW'(in_data.y_pos) * PW'(MY);
    prod_s   = PW'(y_sum_in) * PW'(MY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
    end
    if (advance && in_valid) begin
      a_item <= in_data;
      a_qx   <= prod_x[PW-1:RECIP_SHIFT];
      a_qy   <= prod_y[PW-1:RECIP_SHIFT];
      a_qs   <= prod_s[PW-1:RECIP_SHIFT];
    end
  end

  // Second stage: remainders, row classification and the row mask.
  always_comb begin
    y_sum_a = QW'(a_item.y_pos) + QW'(a_item.row_number);
    h_full  = QW'(a_item.x_pos) - a_qx * QW'(SCREEN_WIDTH);
    v_full  = QW'(a_item.y_pos) - a_qy * QW'(SCREEN_HEIGHT);
    w_full  = y_sum_a - a_qs * QW'(SCREEN_HEIGHT);
    y_clip  = v_full + QW'(a_item.row_number);

    for (int c = 0; c < SPRITE_W; c++) begin
      rev_bits[c] = a_item.row_bits[SPRITE_W-1-c];
    end
    ext = EW'(rev_bits) << h_full[XW-1:0];

    cmd_ctrl.op        = op_t'(a_item.op);
    cmd_ctrl.row_start = (a_item.row_number == '0);
    cmd_ctrl.row_ok    = !clip_mode || (y_clip < QW'(SCREEN_HEIGHT));
    cmd_col            = h_full[XW-1:0];

    if (cmd_ctrl.op == OP_READ) begin
      cmd_row = v_full[YW-1:0];
    end else if (clip_mode) begin
      cmd_row = y_clip[YW-1:0];
    end else begin
      cmd_row = w_full[YW-1:0];
    end

    // Pixels past the right edge fold back to column zero unless clipped.
    if (clip_mode) begin
      cmd_mask = ext[SCREEN_WIDTH-1:0];
    end else begin
      cmd_mask = ext[SCREEN_WIDTH-1:0] | SCREEN_WIDTH'(ext[EW-1:SCREEN_WIDTH]);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sxf_fifo.sv
`default_nettype none

module sxf_fifo
  import sxf_pkg::*;
#(
  parameter int DW    = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          pop,
  output logic [DW-1:0]      rd_data,
  output logic               full,
  output logic               empty
);

  logic [DW-1:0] entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sxf_back.sv
`default_nettype none

module sxf_back
  import sxf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  localparam int XW = $clog2(SCREEN_WIDTH),
  localparam int YW = $clog2(SCREEN_HEIGHT)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cmd_valid,
  output logic                         cmd_pop,
  input  wire cmd_ctrl_t               cmd_ctrl,
  input  wire logic [YW-1:0]           cmd_row,
  input  wire logic [XW-1:0]           cmd_col,
  input  wire logic [SCREEN_WIDTH-1:0] cmd_mask,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output out_item_t                    out_data
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                  state;
  logic                    hit;
  cmd_ctrl_t               ex_ctrl;
  logic [YW-1:0]           ex_row;
  logic [XW-1:0]           ex_col;
  logic [SCREEN_WIDTH-1:0] ex_mask;
  logic [SCREEN_WIDTH-1:0] rd_word;
  logic                    rd_live;
  logic [SCREEN_HEIGHT-1:0] row_valid;

  logic [SCREEN_WIDTH-1:0] frame_mem [SCREEN_HEIGHT];

  logic                    fire;
  logic                    draw_go;
  logic [SCREEN_WIDTH-1:0] cur_word;
  logic                    hit_next;
  logic                    pixel;

  always_comb begin
    cmd_pop  = (state == ST_IDLE) && cmd_valid;
    fire     = (state == ST_EXEC) && (!out_valid || out_ready);
    cur_word = rd_live ? rd_word : '0;
    draw_go  = fire && (ex_ctrl.op == OP_DRAW) && ex_ctrl.row_ok;
    pixel    = (ex_ctrl.op == OP_READ) ? cur_word[ex_col] : 1'b0;
    case (ex_ctrl.op)
      OP_DRAW: begin
        hit_next = (hit && !ex_ctrl.row_start) ||
                   (ex_ctrl.row_ok && |(cur_word & ex_mask));
      end
      default: begin
        hit_next = hit;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (draw_go) begin
      frame_mem[ex_row] <= cur_word ^ ex_mask;
    end
    if (cmd_pop) begin
      rd_word <= frame_mem[cmd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hit       <= 1'b0;
      out_valid <= 1'b0;
      row_valid <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            state   <= ST_EXEC;
            rd_live <= row_valid[cmd_row];
            ex_ctrl <= cmd_ctrl;
            ex_row  <= cmd_row;
            ex_col  <= cmd_col;
            ex_mask <= cmd_mask;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state                <= ST_IDLE;
            hit                  <= hit_next;
            out_data.collision   <= hit_next;
            out_data.pixel_value <= pixel;
            if (ex_ctrl.op == OP_CLEAR) begin
              row_valid <= '0;
            end else if (draw_go) begin
              row_valid[ex_row] <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sprite_xor_framebuffer.sv
// A transaction passes the front's holding register, a queue entry and the back's
// execute registers, then its result is registered. The back takes no new command until
// the last is done; a draw reads and rewrites a row on the frame memory's single port.
// Reset (synchronous, active high): the screen reads blank, the collision flag and
// clip mode are zero and front stage and queue are empty; no clearing pass is needed.
`default_nettype none

module sprite_xor_framebuffer
  import sxf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);
  // A queue entry carries the classified command, the target row, the column
  // for reads and the XOR mask already placed across the whole row word.
  localparam int DW = $bits(cmd_ctrl_t) + YW + XW + SCREEN_WIDTH;

  logic clip_mode;

  // Front to queue.
  logic                    f_valid;
  cmd_ctrl_t               f_ctrl;
  logic [YW-1:0]           f_row;
  logic [XW-1:0]           f_col;
  logic [SCREEN_WIDTH-1:0] f_mask;

  // Queue to back.
  logic                    q_full;
  logic                    q_empty;
  logic                    q_push;
  logic                    q_pop;
  logic [DW-1:0]           q_head;
  cmd_ctrl_t               b_ctrl;
  logic [YW-1:0]           b_row;
  logic [XW-1:0]           b_col;
  logic [SCREEN_WIDTH-1:0] b_mask;

  // Clip mode must only be written while the block is idle (the block itself does not
  // enforce it), so that every queued command was classified under the value now in force.
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      clip_mode <= cfg_wr_data;
    end
  end

  // The front reduces the coordinates modulo the screen size, decides whether
  // a sprite row lands on screen and builds the row mask. It has a single
  // holding stage, so it keeps accepting as long as the queue has room.
  sxf_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .clip_mode (clip_mode),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (!q_full),
    .cmd_ctrl  (f_ctrl),
    .cmd_row   (f_row),
    .cmd_col   (f_col),
    .cmd_mask  (f_mask)
  );

  assign q_push = f_valid && !q_full;

  sxf_fifo #(
    .DW    (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data ({f_ctrl, f_row, f_col, f_mask}),
    .pop     (q_pop),
    .rd_data (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign {b_ctrl, b_row, b_col, b_mask} = q_head;

  // The back holds the frame memory, one word per screen row, with a valid
  // bit per row so that a clear, and reset, blank the screen at once. Each
  // command reads its row as it leaves the queue; an on-screen draw writes
  // it back once the output register is free, as the result goes there.
  sxf_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd_pop   (q_pop),
    .cmd_ctrl  (b_ctrl),
    .cmd_row   (b_row),
    .cmd_col   (b_col),
    .cmd_mask  (b_mask),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The back must never take a command from an empty queue.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command taken from an empty queue");

  // The front always writes into the queue when it holds a command and there is room.
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    f_valid && !q_full |-> q_push)
    else $error("front command not moved into a free queue");

  // The input side may stall only when the queue is full.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_full)
    else $error("input stalled while the queue has room");

  // No result is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

`default_nettype wire

FILE: sim/sxf_checker.sv
`default_nettype none

module sxf_checker
  import sxf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_wr_en,
  input  wire logic      cfg_wr_data,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_item_t out_data,
  output int             mismatch_count,
  output int             results_due
);

  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

  // Shadow copy of the screen, the sticky flag and the clip setting.
  bit          screen_bits [PIXELS];
  bit          hit_seen;
  bit          clip_on;
  out_item_t   expected_flags [$];
  int unsigned result_no;

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", result_no, what);
    mismatch_count++;
  endtask

  // Applies one command to the shadow screen and returns the result it should give.
  function automatic out_item_t draw_or_read(input in_item_t cmd);
    out_item_t   res;
    int unsigned left_col;
    int unsigned screen_row;
    int unsigned col;
    int unsigned idx;
    int          i;
    logic        pix;
    res = '0;
    case (cmd.op)
      OP_CLEAR: begin
        for (i = 0; i < PIXELS; i++) screen_bits[i] = 1'b0;
      end
      OP_DRAW: begin
        left_col   = cmd.x_pos % SCREEN_WIDTH;
        screen_row = (cmd.y_pos % SCREEN_HEIGHT) + cmd.row_number;
        if (cmd.row_number == 0) hit_seen = 1'b0;
        if (!(clip_on && screen_row >= SCREEN_HEIGHT)) begin
          screen_row = screen_row % SCREEN_HEIGHT;
          for (i = 0; i < SPRITE_W; i++) begin
            col = left_col + i;
            if (clip_on && col >= SCREEN_WIDTH) break;
            col = col % SCREEN_WIDTH;
            idx = screen_row * SCREEN_WIDTH + col;
            pix = cmd.row_bits[SPRITE_W - 1 - i];
            if (pix && screen_bits[idx]) hit_seen = 1'b1;
            screen_bits[idx] = screen_bits[idx] ^ pix;
          end
        end
      end
      OP_READ: begin
        idx = (cmd.y_pos % SCREEN_HEIGHT) * SCREEN_WIDTH + (cmd.x_pos % SCREEN_WIDTH);
        res.pixel_value = screen_bits[idx];
      end
      default: ;
    endcase
    res.collision = hit_seen;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    int        i;
    if (rst) begin
      for (i = 0; i < PIXELS; i++) screen_bits[i] = 1'b0;
      hit_seen = 1'b0;
      clip_on = 1'b0;
      expected_flags.delete();
      result_no = 0;
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) clip_on = cfg_wr_data;
      // Results are retired before new commands are queued, so an unexpected
      // result is never paired with a command accepted at the same edge.
      if (out_valid && out_ready) begin
        if (expected_flags.size() == 0) begin
          report_mismatch("result arrived with nothing outstanding");
        end else begin
          want = expected_flags.pop_front();
          if (out_data.collision !== want.collision)
            report_mismatch($sformatf("collision %b, expected %b",
                                      out_data.collision, want.collision));
          if (out_data.pixel_value !== want.pixel_value)
            report_mismatch($sformatf("pixel_value %b, expected %b",
                                      out_data.pixel_value, want.pixel_value));
        end
        result_no++;
      end
      if (in_valid && in_ready) expected_flags.push_back(draw_or_read(in_data));
    end
    results_due <= expected_flags.size();
  end

endmodule

`default_nettype wire

FILE: sim/sprite_xor_framebuffer_tb.sv
`default_nettype none

module sprite_xor_framebuffer_tb;
  import sxf_pkg::*;

  // Generous ceiling: every transaction waiting out a full sender gap and a
  // full receiver stall comes to well under a fifth of this.
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 240;
  localparam int PHASES      = 8;
  localparam int DRAIN_SLACK = 8;
  localparam int IN_W        = $bits(in_item_t);

  logic      clk         = 1'b0;
  logic      rst         = 1'b1;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid    = 1'b0;
  in_item_t  in_data     = '0;
  logic      out_ready   = 1'b1;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  int          mismatch_count;
  int          results_due;
  bit          gaps_on = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;

  // The sprite most recently drawn, kept so that it can be drawn again over
  // itself (which erases it and raises the collision flag) and probed.
  logic [7:0] sprite_x = 8'd0;
  logic [7:0] sprite_y = 8'd0;
  int         sprite_h = 1;
  logic [7:0] sprite_rows [16];

  sprite_xor_framebuffer uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  sxf_checker pixel_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .results_due   (results_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls in random bursts while idling is enabled, and otherwise
  // accepts every result straight away.
  always @(posedge clk) begin
    if (rst || !gaps_on) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_item_t make_item(input op_t op, input logic [7:0] x,
                                         input logic [7:0] y, input logic [3:0] row,
                                         input logic [7:0] bits);
    in_item_t item;
    item.op = op;
    item.x_pos = x;
    item.y_pos = y;
    item.row_number = row;
    item.row_bits = bits;
    return item;
  endfunction

  // Biased towards the screen edges, where wrapping and clipping happen, but
  // the whole 8-bit range is covered as well.
  function automatic logic [7:0] pick_coord(input int extent);
    case ($urandom_range(0, 3))
      0: pick_coord = 8'(extent - SPRITE_W + $urandom_range(0, SPRITE_W - 1));
      1: pick_coord = 8'($urandom_range(0, 7));
      default: pick_coord = 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Presents one transaction and holds it until accepted. Valid is left high
  // so that a following transaction can go out back to back; any task that
  // lets time pass without sending lowers it first.
  task automatic send(input in_item_t item);
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // The first edge lets the count catch up with a transaction accepted just now.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic set_clip(input logic clip);
    wait_all_results();
    repeat (DRAIN_SLACK) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= clip;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly a proper sprite from row 0 upwards; now and then the opening rows
  // are missing, so the flag is not cleared when the sprite starts.
  task automatic draw_sprite();
    int first_row;
    int r;
    first_row = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    for (r = first_row; r < sprite_h; r++)
      send(make_item(OP_DRAW, sprite_x, sprite_y, r[3:0], sprite_rows[r]));
  endtask

  task automatic new_sprite();
    int r;
    sprite_x = pick_coord(SCREEN_WIDTH_DEF);
    sprite_y = pick_coord(SCREEN_HEIGHT_DEF);
    sprite_h = $urandom_range(1, 16);
    for (r = 0; r < 16; r++) sprite_rows[r] = 8'($urandom);
  endtask

  // Reads a few pixels in and just around the last sprite.
  task automatic probe_sprite();
    repeat (4)
      send(make_item(OP_READ, 8'(sprite_x + $urandom_range(0, 9)),
                     8'(sprite_y + $urandom_range(0, 16)), 4'($urandom), 8'($urandom)));
  endtask

  task automatic run_phase(input int quota);
    int unsigned start;
    int          pick;
    bit          paused;
    start = items_sent;
    paused = 1'b0;
    while (items_sent - start < quota) begin
      // Halfway through, the sender holds off until the pipeline is empty.
      if (!paused && items_sent - start >= quota / 2) begin
        wait_all_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        new_sprite();
        draw_sprite();
      end else if (pick < 65) begin
        draw_sprite();
      end else if (pick < 88) begin
        probe_sprite();
      end else if (pick < 90) begin
        send(make_item(OP_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom)));
      end else begin
        send(in_item_t'(IN_W'($urandom)));
      end
    end
  endtask

  initial begin
    int p;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wrap mode straight after reset.
    send(make_item(OP_CLEAR, 8'd0, 8'd0, 4'd0, 8'h00));
    send(make_item(OP_READ, 8'd0, 8'd0, 4'd0, 8'h00));
    send(make_item(OP_DRAW, 8'd0, 8'd0, 4'd0, 8'hff));
    send(make_item(OP_DRAW, 8'd255, 8'd255, 4'd15, 8'h81));
    send(make_item(OP_DRAW, 8'd60, 8'd30, 4'd1, 8'haa));
    send(make_item(OP_DRAW, 8'd0, 8'd0, 4'd1, 8'h80));
    // Row 0 clears the flag, then erasing a lit pixel sets it again.
    send(make_item(OP_DRAW, 8'd0, 8'd0, 4'd0, 8'h80));
    send(make_item(OP_READ, 8'd0, 8'd0, 4'd0, 8'h00));
    send(make_item(OP_READ, 8'd1, 8'd0, 4'd0, 8'h00));
    send(make_item(OP_READ, 8'd255, 8'd255, 4'd15, 8'hff));
    send(make_item(OP_READ, 8'd63, 8'd14, 4'd0, 8'h00));
    send(make_item(OP_DRAW, 8'd0, 8'd0, 4'd2, 8'h00));
    send(make_item(OP_NONE, 8'd255, 8'd255, 4'd15, 8'hff));
    // A clear keeps the collision flag as it was.
    send(make_item(OP_CLEAR, 8'd255, 8'd255, 4'd15, 8'hff));
    send(make_item(OP_READ, 8'd1, 8'd0, 4'd0, 8'h00));

    // Clip mode: the sprite is cut at the right edge and below the bottom row.
    set_clip(1'b1);
    send(make_item(OP_DRAW, 8'd60, 8'd30, 4'd0, 8'hff));
    send(make_item(OP_DRAW, 8'd60, 8'd30, 4'd1, 8'hff));
    send(make_item(OP_DRAW, 8'd60, 8'd30, 4'd2, 8'hff));
    send(make_item(OP_DRAW, 8'd60, 8'd30, 4'd15, 8'hff));
    send(make_item(OP_DRAW, 8'd255, 8'd255, 4'd0, 8'hff));
    send(make_item(OP_READ, 8'd63, 8'd31, 4'd0, 8'h00));
    send(make_item(OP_READ, 8'd60, 8'd30, 4'd0, 8'h00));
    send(make_item(OP_READ, 8'd64, 8'd30, 4'd0, 8'h00));
    send(make_item(OP_DRAW, 8'd0, 8'd0, 4'd0, 8'hff));
    send(make_item(OP_DRAW, 8'd0, 8'd0, 4'd0, 8'hff));

    // Random phases alternate between the two modes; one stretch in the
    // middle and the closing phase run without any idling.
    for (p = 0; p < PHASES; p++) begin
      set_clip(p[0]);
      gaps_on <= (p != 3 && p != PHASES - 1);
      run_phase(PHASE_ITEMS);
    end

    wait_all_results();
    repeat (DRAIN_SLACK * 2) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/sxf_pkg.sv
rtl/core/sxf_front.sv
rtl/core/sxf_fifo.sv
rtl/core/sxf_back.sv
rtl/core/sprite_xor_framebuffer.sv
sim/sxf_checker.sv
sim/sprite_xor_framebuffer_tb.sv
